// File: hdl/mach_zehnder_field_modulator_top_macros.svh
// Assertion macros for the Mach-Zehnder field modulator.
// Used by mach_zehnder_field_modulator_top; depends on nothing.
`ifndef MACH_ZEHNDER_FIELD_MODULATOR_TOP_MACROS_SVH
`define MACH_ZEHNDER_FIELD_MODULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MZM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MZM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MZM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MZM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/mzfm_pkg.sv
// Package for the Mach-Zehnder field modulator: register indexes, CORDIC constants.
// No dependencies.
`default_nettype none
package mzfm_pkg;
   typedef enum logic [2:0] {
      REG_MODE = 3'd0, REG_INV_VPI = 3'd1, REG_BIAS_UPPER = 3'd2,
      REG_BIAS_LOWER = 3'd3, REG_GAMMA = 3'd4, REG_OUT_GAIN = 3'd5
   } reg_index_type;

   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// File: hdl/mach_zehnder_field_modulator_top.sv
// Stages: drive, phase fold, CORDIC, gamma, arm sum, gain, products, output.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is free or being taken, so stall depth is the pipeline itself.
// Reset: synchronous, active high; clears valid bits and loads register defaults.
// Depends on mzfm_pkg and mach_zehnder_field_modulator_top_macros.svh.
`default_nettype none
`include "mach_zehnder_field_modulator_top_macros.svh"
module mach_zehnder_field_modulator_top #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire signed [SAMPLE_WIDTH-1:0] req_drive_sample,
   input  wire signed [SAMPLE_WIDTH-1:0] req_x_re,
   input  wire signed [SAMPLE_WIDTH-1:0] req_x_im,
   input  wire signed [SAMPLE_WIDTH-1:0] req_y_re,
   input  wire signed [SAMPLE_WIDTH-1:0] req_y_im,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_x_re,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_x_im,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_y_re,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_y_im,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire  [4:0]                    paddr,
   input  wire  [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   localparam int NS = (CORDIC_STAGES < mzfm_pkg::ATAN_ENTRIES) ?
                       CORDIC_STAGES : mzfm_pkg::ATAN_ENTRIES;
   localparam int W = SAMPLE_WIDTH;
   localparam int NP = NS + 7;
   localparam logic signed [W+2:0] SAT_HI = (W+3)'((64'sd1 <<< (W-1)) - 1);
   localparam logic signed [W+2:0] SAT_LO = -SAT_HI - (W+3)'(1);

   // configuration registers
   logic        mode_ff;
   logic [15:0] inv_vpi_ff, bias_u_ff, bias_l_ff, gamma_ff, gain_ff;
   logic [2:0]  widx;
   assign widx = paddr[4:2];
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; inv_vpi_ff <= 16'd2608; bias_u_ff <= 16'hF000;
         bias_l_ff <= 16'hF000; gamma_ff <= 16'd32768; gain_ff <= 16'd8192;
      end else if (psel && penable && pwrite) begin
         case (widx)
            mzfm_pkg::REG_MODE:       mode_ff <= pwdata[0];
            mzfm_pkg::REG_INV_VPI:    inv_vpi_ff <= pwdata[15:0];
            mzfm_pkg::REG_BIAS_UPPER: bias_u_ff <= pwdata[15:0];
            mzfm_pkg::REG_BIAS_LOWER: bias_l_ff <= pwdata[15:0];
            mzfm_pkg::REG_GAMMA:      gamma_ff <= pwdata[15:0];
            mzfm_pkg::REG_OUT_GAIN:   gain_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (widx)
         mzfm_pkg::REG_MODE:       prdata = {31'd0, mode_ff};
         mzfm_pkg::REG_INV_VPI:    prdata = {16'd0, inv_vpi_ff};
         mzfm_pkg::REG_BIAS_UPPER: prdata = {16'd0, bias_u_ff};
         mzfm_pkg::REG_BIAS_LOWER: prdata = {16'd0, bias_l_ff};
         mzfm_pkg::REG_GAMMA:      prdata = {16'd0, gamma_ff};
         mzfm_pkg::REG_OUT_GAIN:   prdata = {16'd0, gain_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   // pipeline control
   logic            adv;
   logic [NP-1:0]   vld_ff;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NP-2:0], req_valid};
   end

   // field samples travel alongside
   logic signed [W-1:0] fxr_ff [NP-2], fxi_ff [NP-2], fyr_ff [NP-2], fyi_ff [NP-2];
   always_ff @(posedge clock) begin
      if (adv) begin
         fxr_ff[0] <= req_x_re; fxi_ff[0] <= req_x_im;
         fyr_ff[0] <= req_y_re; fyi_ff[0] <= req_y_im;
         for (int k = 1; k < NP-2; k++) begin
            fxr_ff[k] <= fxr_ff[k-1]; fxi_ff[k] <= fxi_ff[k-1];
            fyr_ff[k] <= fyr_ff[k-1]; fyi_ff[k] <= fyi_ff[k-1];
         end
      end
   end

   // stage 0: drive product
   logic signed [W+16:0] drv_ff;
   always_ff @(posedge clock) begin
      if (adv) drv_ff <= (W+17)'(req_drive_sample) * $signed({1'b0, inv_vpi_ff});
   end

   // stage 1: phases and quadrant fold
   logic signed [W+17:0] vu, vl;
   logic [31:0] pu, pl, pu2, pl2;
   logic signed [33:0] zu_ff, zl_ff, xu_ff, xl_ff;
   always_comb begin
      vu = (W+18)'(drv_ff) + (W+18)'($signed(bias_u_ff)) * (W+18)'(4096);
      vl = (W+18)'(drv_ff) + (W+18)'($signed(bias_l_ff)) * (W+18)'(4096);
      if (mode_ff) begin
         pu = 32'(vu <<< 7); pl = 32'(vl <<< 7);
      end else begin
         pu = 32'(vu <<< 6); pl = 32'(-(vl <<< 6));
      end
      pu2 = pu; pl2 = pl;
      if (pu[31] ^ pu[30]) pu2[31] = ~pu[31];
      if (pl[31] ^ pl[30]) pl2[31] = ~pl[31];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         zu_ff <= 34'($signed(pu2)); zl_ff <= 34'($signed(pl2));
         xu_ff <= (pu[31] ^ pu[30]) ? -mzfm_pkg::CORDIC_GAIN : mzfm_pkg::CORDIC_GAIN;
         xl_ff <= (pl[31] ^ pl[30]) ? -mzfm_pkg::CORDIC_GAIN : mzfm_pkg::CORDIC_GAIN;
      end
   end

   // CORDIC stages
   logic signed [33:0] cx_u [NS+1], cy_u [NS+1], cz_u [NS+1];
   logic signed [33:0] cx_l [NS+1], cy_l [NS+1], cz_l [NS+1];
   assign cx_u[0] = xu_ff; assign cy_u[0] = '0; assign cz_u[0] = zu_ff;
   assign cx_l[0] = xl_ff; assign cy_l[0] = '0; assign cz_l[0] = zl_ff;
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      logic signed [33:0] xu_s_ff, yu_s_ff, zu_s_ff, xl_s_ff, yl_s_ff, zl_s_ff;
      logic signed [33:0] at;
      assign at = mzfm_pkg::atan_turn(5'(i));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!cz_u[i][33]) begin
               xu_s_ff <= cx_u[i] - (cy_u[i] >>> i);
               yu_s_ff <= cy_u[i] + (cx_u[i] >>> i);
               zu_s_ff <= cz_u[i] - at;
            end else begin
               xu_s_ff <= cx_u[i] + (cy_u[i] >>> i);
               yu_s_ff <= cy_u[i] - (cx_u[i] >>> i);
               zu_s_ff <= cz_u[i] + at;
            end
            if (!cz_l[i][33]) begin
               xl_s_ff <= cx_l[i] - (cy_l[i] >>> i);
               yl_s_ff <= cy_l[i] + (cx_l[i] >>> i);
               zl_s_ff <= cz_l[i] - at;
            end else begin
               xl_s_ff <= cx_l[i] + (cy_l[i] >>> i);
               yl_s_ff <= cy_l[i] - (cx_l[i] >>> i);
               zl_s_ff <= cz_l[i] + at;
            end
         end
      end
      assign cx_u[i+1] = xu_s_ff; assign cy_u[i+1] = yu_s_ff; assign cz_u[i+1] = zu_s_ff;
      assign cx_l[i+1] = xl_s_ff; assign cy_l[i+1] = yl_s_ff; assign cz_l[i+1] = zl_s_ff;
   end

   // gamma weighting of the lower arm
   logic signed [50:0] gc_ff, gs_ff;
   logic signed [33:0] cu_ff, su_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         gc_ff <= 51'(cx_l[NS]) * $signed({35'd0, gamma_ff});
         gs_ff <= 51'(cy_l[NS]) * $signed({35'd0, gamma_ff});
         cu_ff <= cx_u[NS]; su_ff <= cy_u[NS];
      end
   end
   logic signed [35:0] hr_ff, hi_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hr_ff <= 36'(cu_ff) + 36'(gc_ff >>> 15);
         hi_ff <= 36'(su_ff) + 36'(gs_ff >>> 15);
      end
   end
   // out_gain scaling
   logic signed [52:0] tr_p_ff, ti_p_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         tr_p_ff <= 53'(hr_ff) * $signed({37'd0, gain_ff});
         ti_p_ff <= 53'(hi_ff) * $signed({37'd0, gain_ff});
      end
   end
   logic signed [32:0] tr, ti;
   assign tr = 33'(tr_p_ff >>> 20);
   assign ti = 33'(ti_p_ff >>> 20);

   // field products
   localparam int PW = W + 34;
   logic signed [PW-1:0] xa_ff, xb_ff, xc_ff, xd_ff, ya_ff, yb_ff, yc_ff, yd_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff <= PW'(fxr_ff[NP-3]) * PW'(tr); xb_ff <= PW'(fxi_ff[NP-3]) * PW'(ti);
         xc_ff <= PW'(fxr_ff[NP-3]) * PW'(ti); xd_ff <= PW'(fxi_ff[NP-3]) * PW'(tr);
         ya_ff <= PW'(fyr_ff[NP-3]) * PW'(tr); yb_ff <= PW'(fyi_ff[NP-3]) * PW'(ti);
         yc_ff <= PW'(fyr_ff[NP-3]) * PW'(ti); yd_ff <= PW'(fyi_ff[NP-3]) * PW'(tr);
      end
   end

   function automatic logic signed [W-1:0] rsat(input logic signed [PW:0] p);
      logic signed [PW:0] r;
      logic signed [W+2:0] q;
      logic ovh, ovl;
      r = (p + (PW+1)'(64'sd1 <<< 23)) >>> 24;
      ovh = (r > (PW+1)'(SAT_HI));
      ovl = (r < (PW+1)'(SAT_LO));
      q = ovh ? SAT_HI : (ovl ? SAT_LO : (W+3)'(r));
      return W'(q);
   endfunction

   logic signed [PW:0] sxr, sxi, syr, syi;
   assign sxr = (PW+1)'(xa_ff) - (PW+1)'(xb_ff);
   assign sxi = (PW+1)'(xc_ff) + (PW+1)'(xd_ff);
   assign syr = (PW+1)'(ya_ff) - (PW+1)'(yb_ff);
   assign syi = (PW+1)'(yc_ff) + (PW+1)'(yd_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_out_x_re <= rsat(sxr); rsp_out_x_im <= rsat(sxi);
         rsp_out_y_re <= rsat(syr); rsp_out_y_im <= rsat(syi);
      end
   end
   assign rsp_valid = vld_ff[NP-1];

   `MZM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response lost during stall")
   `MZM_ASSERT_IMPL(a_ready_link, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request stalled without output stall")
   `MZM_ASSERT_NEXT(a_out_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_x_re) && $stable(rsp_out_y_im), "response changed during stall")
endmodule
`default_nettype wire
